// ===== design/sma_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sma_pkg
// shared types, codes and sizes of the stack machine alu
// ----------------------------------------------------------------------------
package sma_pkg;

  localparam int WORD_W          = 32;
  localparam int ACTION_W        = 4;
  localparam int STATUS_W        = 3;
  localparam int DEPTH_W         = 9;
  localparam int SMA_STACK_DEPTH = 256;

  // operation codes
  localparam logic [ACTION_W-1:0] ACT_PUSH   = 4'd0;
  localparam logic [ACTION_W-1:0] ACT_PEEK   = 4'd1;
  localparam logic [ACTION_W-1:0] ACT_ADD    = 4'd2;
  localparam logic [ACTION_W-1:0] ACT_SUB    = 4'd3;
  localparam logic [ACTION_W-1:0] ACT_MUL    = 4'd4;
  localparam logic [ACTION_W-1:0] ACT_DIV    = 4'd5;
  localparam logic [ACTION_W-1:0] ACT_MOD    = 4'd6;
  localparam logic [ACTION_W-1:0] ACT_DOUBLE = 4'd7;
  localparam logic [ACTION_W-1:0] ACT_NEGATE = 4'd8;

  // status codes
  localparam logic [STATUS_W-1:0] STAT_OK      = 3'd0;
  localparam logic [STATUS_W-1:0] STAT_UNKNOWN = 3'd1;
  localparam logic [STATUS_W-1:0] STAT_UNDER   = 3'd2;
  localparam logic [STATUS_W-1:0] STAT_DIVZERO = 3'd3;
  localparam logic [STATUS_W-1:0] STAT_FULL    = 3'd4;

  typedef struct packed {
    logic [ACTION_W-1:0]      action;
    logic signed [WORD_W-1:0] operand;
  } in_req_t;

  typedef struct packed {
    logic [STATUS_W-1:0]      status;
    logic signed [WORD_W-1:0] top_value;
    logic                     top_valid;
    logic [DEPTH_W-1:0]       depth;
  } out_resp_t;

  // divider control
  typedef struct packed {
    logic start;
    logic want_rem;
  } div_ctl_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_DIV
  } state_t;

endpackage

// ===== design/stack_machine_alu.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stack_machine_alu
// integer alu working on a bounded operand stack held in a synchronous ram
// ----------------------------------------------------------------------------
// One request runs one operation (push, peek, add, sub, mul, div, mod, double,
// negate) against a stack of 32-bit signed words and returns one response
// with a status code, the new top of stack and the new depth. The top of the
// stack lives in a register and the entries below it in a one-port-write,
// registered-read ram, so a binary operation needs one ram read of the second
// entry. Requests are taken one at a time: push, peek, add, sub, mul, double,
// negate and every error case pass through accept, then execute and commit;
// div and mod also launch the 32-step one-bit-per-cycle divider between
// accept and commit and wait for it to finish. A finished response sits in
// an output register, and the next request is accepted while it waits; a
// commit waits until that register is free. The stack ram has no reset; only
// entries below the current depth are ever used.
// ----------------------------------------------------------------------------
module stack_machine_alu
  import sma_pkg::*;
#(
  parameter int STACK_DEPTH = SMA_STACK_DEPTH
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_req_t   in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_resp_t out_data
);

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);

  // control and stack state
  state_t            state_r, state_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic [WORD_W-1:0] top_r, top_nxt;
  in_req_t           req_r, req_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_resp_t         out_data_r, out_data_nxt;

  // ram port
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [AW-1:0]     mem_raddr;
  logic [WORD_W-1:0] mem_rdata;

  // divider
  div_ctl_t          div_ctl;
  logic              div_busy;
  logic [WORD_W-1:0] div_result;

  // execute results
  logic [STATUS_W-1:0] res_status;
  logic [WORD_W-1:0]   res_top;
  logic [CW-1:0]       res_count;
  logic                res_push_spill;
  logic                res_div;
  logic                slot_free;
  logic                commit;
  logic [WORD_W-1:0]   b_val, t_val;
  logic [WORD_W-1:0]   mul_res;

  // second entry sits at count - 2, top spills to count - 1 on push
  assign mem_raddr = AW'(count_r - CW'(2));
  assign mem_waddr = AW'(count_r - CW'(1));

  sma_stack_ram #(
    .DEPTH (STACK_DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (top_r),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  sma_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (div_ctl),
    .dividend (b_val),
    .divisor  (t_val),
    .busy     (div_busy),
    .result   (div_result)
  );

  assign b_val   = mem_rdata;
  assign t_val   = top_r;
  assign mul_res = WORD_W'(b_val * t_val);

  // operation decode, result of the latched request
  always_comb begin
    res_status     = STAT_OK;
    res_top        = top_r;
    res_count      = count_r;
    res_push_spill = 1'b0;
    res_div        = 1'b0;
    case (req_r.action) inside
      ACT_PUSH: begin
        if (count_r >= CW'(STACK_DEPTH)) begin
          res_status = STAT_FULL;
        end else begin
          // old top moves into the ram unless the stack was empty
          res_push_spill = (count_r != '0);
          res_top        = req_r.operand;
          res_count      = count_r + CW'(1);
        end
      end
      ACT_PEEK, ACT_DOUBLE, ACT_NEGATE: begin
        if (count_r == '0) begin
          res_status = STAT_UNDER;
        end else if (req_r.action == ACT_DOUBLE) begin
          res_top = {t_val[WORD_W-2:0], 1'b0};
        end else if (req_r.action == ACT_NEGATE) begin
          res_top = ~t_val + WORD_W'(1);
        end
      end
      ACT_ADD, ACT_SUB, ACT_MUL, ACT_DIV, ACT_MOD: begin
        if (count_r < CW'(2)) begin
          res_status = STAT_UNDER;
        end else begin
          res_count = count_r - CW'(1);
          case (req_r.action)
            ACT_ADD: res_top = b_val + t_val;
            ACT_SUB: res_top = b_val - t_val;
            ACT_MUL: res_top = mul_res;
            default: begin
              if (t_val == '0) begin
                // divide by zero leaves the stack alone
                res_status = STAT_DIVZERO;
                res_count  = count_r;
              end else begin
                res_div = 1'b1;
                res_top = div_result;
              end
            end
          endcase
        end
      end
      default: res_status = STAT_UNKNOWN;
    endcase
  end

  assign slot_free = !out_valid_r || out_ready;

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    req_nxt        = req_r;
    in_ready       = 1'b0;
    commit         = 1'b0;
    div_ctl.start    = 1'b0;
    div_ctl.want_rem = (req_r.action == ACT_MOD);
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          req_nxt   = in_data;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        // ram read of the second entry is valid here
        if (res_div) begin
          div_ctl.start = 1'b1;
          state_nxt     = S_DIV;
        end else if (slot_free) begin
          commit    = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_DIV: begin
        if (!div_busy && slot_free) begin
          commit    = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign mem_we = commit && res_push_spill;

  // stack and response update
  always_comb begin
    count_nxt     = count_r;
    top_nxt       = top_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    if (commit) begin
      count_nxt              = res_count;
      top_nxt                = res_top;
      out_valid_nxt          = 1'b1;
      out_data_nxt.status    = res_status;
      out_data_nxt.top_valid = (res_count != '0);
      out_data_nxt.top_value = (res_count != '0) ? res_top : '0;
      out_data_nxt.depth     = DEPTH_W'(res_count);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    top_r      <= top_nxt;
    req_r      <= req_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // one request in flight at a time
  a_single_request : assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while another is in flight");

  // depth stays within the stack
  a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(STACK_DEPTH))
    else $error("stack count beyond stack depth");

  // ram is written only by a push onto a non-empty, non-full stack
  a_spill_legal : assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (count_r != '0) && (count_r < CW'(STACK_DEPTH)) &&
               (req_r.action == ACT_PUSH))
    else $error("illegal stack ram write");

  // divider runs only while the sequencer waits for it
  a_div_owner : assert property (@(posedge clk) disable iff (!rst_n)
    div_busy |-> state_r == S_DIV)
    else $error("divider busy outside divide wait");

endmodule

// ===== design/sma_stack_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sma_stack_ram
// operand stack storage, one write and one registered read port
// ----------------------------------------------------------------------------
module sma_stack_ram
  import sma_pkg::*;
#(
  parameter int DEPTH = SMA_STACK_DEPTH,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  logic [WORD_W-1:0] wdata,
  input  logic [AW-1:0]     raddr,
  output logic [WORD_W-1:0] rdata
);

  logic [WORD_W-1:0] mem [DEPTH];
  logic [WORD_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== design/sma_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sma_div
// signed restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module sma_div
  import sma_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  div_ctl_t          ctl,
  input  logic [WORD_W-1:0] dividend,
  input  logic [WORD_W-1:0] divisor,
  output logic              busy,
  output logic [WORD_W-1:0] result
);

  localparam int CNT_W = $clog2(WORD_W);

  logic              busy_r, busy_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [WORD_W-1:0] rem_r, rem_nxt;
  logic [WORD_W-1:0] quo_r, quo_nxt;
  logic [WORD_W-1:0] dvs_r, dvs_nxt;
  logic              neg_q_r, neg_q_nxt;
  logic              neg_r_r, neg_r_nxt;
  logic              want_rem_r, want_rem_nxt;

  logic [WORD_W:0]   shifted;
  logic [WORD_W:0]   diff;
  logic              na, nb;

  always_comb begin
    na           = dividend[WORD_W-1];
    nb           = divisor[WORD_W-1];
    shifted      = {rem_r, quo_r[WORD_W-1]};
    diff         = shifted - {1'b0, dvs_r};
    busy_nxt     = busy_r;
    cnt_nxt      = cnt_r;
    rem_nxt      = rem_r;
    quo_nxt      = quo_r;
    dvs_nxt      = dvs_r;
    neg_q_nxt    = neg_q_r;
    neg_r_nxt    = neg_r_r;
    want_rem_nxt = want_rem_r;
    if (ctl.start) begin
      // work on magnitudes, fix signs at the end
      busy_nxt     = 1'b1;
      cnt_nxt      = CNT_W'(WORD_W - 1);
      rem_nxt      = '0;
      quo_nxt      = na ? (~dividend + WORD_W'(1)) : dividend;
      dvs_nxt      = nb ? (~divisor + WORD_W'(1)) : divisor;
      neg_q_nxt    = na ^ nb;
      neg_r_nxt    = na;
      want_rem_nxt = ctl.want_rem;
    end else if (busy_r) begin
      rem_nxt = diff[WORD_W] ? shifted[WORD_W-1:0] : diff[WORD_W-1:0];
      quo_nxt = {quo_r[WORD_W-2:0], ~diff[WORD_W]};
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r      <= cnt_nxt;
    rem_r      <= rem_nxt;
    quo_r      <= quo_nxt;
    dvs_r      <= dvs_nxt;
    neg_q_r    <= neg_q_nxt;
    neg_r_r    <= neg_r_nxt;
    want_rem_r <= want_rem_nxt;
  end

  always_comb begin
    if (want_rem_r) begin
      result = neg_r_r ? (~rem_r + WORD_W'(1)) : rem_r;
    end else begin
      result = neg_q_r ? (~quo_r + WORD_W'(1)) : quo_r;
    end
  end

  assign busy = busy_r;

endmodule
